FILE: src/line_follow_pd_steering_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line follower steering block
// Shared property wrappers, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// same-cycle implication
`define LFS_ASSERT_NOW(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (consq)) \
      else $error(msg);

// next-cycle implication
`define LFS_ASSERT_NEXT(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consq)) \
      else $error(msg);

`endif

FILE: src/lfs_pkg.sv
// ---------------------------------------------------------------------------
// lfs_pkg
// Types, constants and helpers shared by the line follower steering block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfs_pkg;

   localparam logic [6:0] WhiteLevel = 7'd47;
   localparam logic [6:0] BlackLevel = 7'd7;

   localparam logic [1:0] STOP_ENCODER    = 2'd0;
   localparam logic [1:0] STOP_WHITE_BLACK = 2'd1;
   localparam logic [1:0] STOP_WHITE      = 2'd2;

   localparam logic [2:0] REG_SETPOINT   = 3'd0;
   localparam logic [2:0] REG_GAIN_P     = 3'd1;
   localparam logic [2:0] REG_GAIN_I     = 3'd2;
   localparam logic [2:0] REG_GAIN_D     = 3'd3;
   localparam logic [2:0] REG_BASE_SPEED = 3'd4;
   localparam logic [2:0] REG_FOLLOW     = 3'd5;
   localparam logic [2:0] REG_STOP_MODE  = 3'd6;
   localparam logic [2:0] REG_ENC_TARGET = 3'd7;

   typedef struct packed {
      logic [7:0]        setpoint_half;
      logic [9:0]        gain_p;
      logic [9:0]        gain_i;
      logic [9:0]        gain_d;
      logic signed [7:0] base_speed;
      logic              follow_side;
      logic [1:0]        stop_mode;
      logic [19:0]       encoder_target;
   } cfg_type;

   // one tick's values, computed with the run-state update, ready for the multipliers
   typedef struct packed {
      logic              done;
      logic signed [8:0]  err;
      logic signed [15:0] err_sum;
      logic signed [9:0]  deriv;
   } tick_type;

   function automatic logic signed [7:0] sat_speed(input logic signed [20:0] v);
      logic signed [7:0] r;
      if (v > 21'sd100) begin
         r = 8'sd100;
      end else if (v < -21'sd100) begin
         r = -8'sd100;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

FILE: src/lfs_csr.sv
// ---------------------------------------------------------------------------
// lfs_csr
// Configuration register file; takes one write per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_wdata,
   output lfs_pkg::cfg_type  cfg
);
   import lfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SETPOINT:   cfg_in.setpoint_half  = csr_wdata[7:0];
            REG_GAIN_P:     cfg_in.gain_p         = csr_wdata[9:0];
            REG_GAIN_I:     cfg_in.gain_i         = csr_wdata[9:0];
            REG_GAIN_D:     cfg_in.gain_d         = csr_wdata[9:0];
            REG_BASE_SPEED: cfg_in.base_speed     = csr_wdata[7:0];
            REG_FOLLOW:     cfg_in.follow_side    = csr_wdata[0];
            REG_STOP_MODE:  cfg_in.stop_mode      = csr_wdata[1:0];
            REG_ENC_TARGET: cfg_in.encoder_target = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint_half  <= 8'd55;
         cfg_ff.gain_p         <= 10'd77;
         cfg_ff.gain_i         <= 10'd0;
         cfg_ff.gain_d         <= 10'd154;
         cfg_ff.base_speed     <= 8'sd30;
         cfg_ff.follow_side    <= 1'b0;
         cfg_ff.stop_mode      <= STOP_ENCODER;
         cfg_ff.encoder_target <= 20'd360;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/lfs_track.sv
// ---------------------------------------------------------------------------
// lfs_track
// Run state: stop detection, error, saturating integral and last error.
// Updated once for every accepted tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_track (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              first_sample,
   input  logic [6:0]        follow_reading,
   input  logic [6:0]        find_reading,
   input  logic [19:0]       encoder_count,
   input  lfs_pkg::cfg_type  cfg,
   output lfs_pkg::tick_type tick
);
   import lfs_pkg::*;

   logic signed [8:0]  last_error_ff, last_error_in;
   logic signed [15:0] error_sum_ff, error_sum_in;
   logic               white_seen_ff, white_seen_in;
   logic               run_finished_ff, run_finished_in;

   logic signed [8:0]  le_cur;
   logic signed [15:0] sum_cur;
   logic               ws_cur;
   logic               rf_cur;
   logic               ws_new;
   logic               stop;
   logic [9:0]         err_wide;
   logic signed [8:0]  err;
   logic signed [16:0] sum_wide;
   logic signed [15:0] sum_sat;
   logic               same_sign;

   // a new run clears everything before the tick is handled
   assign le_cur  = first_sample ? '0 : last_error_ff;
   assign sum_cur = first_sample ? '0 : error_sum_ff;
   assign ws_cur  = first_sample ? 1'b0 : white_seen_ff;
   assign rf_cur  = first_sample ? 1'b0 : run_finished_ff;

   assign ws_new = ws_cur | (find_reading >= WhiteLevel);

   always_comb begin
      case (cfg.stop_mode)
         STOP_ENCODER:     stop = (encoder_count >= cfg.encoder_target);
         STOP_WHITE_BLACK: stop = ws_new & (find_reading <= BlackLevel);
         default:          stop = ws_new;
      endcase
   end

   assign err_wide = {2'b00, follow_reading, 1'b0} - {2'b00, cfg.setpoint_half};
   assign err      = err_wide[8:0];

   assign same_sign = ((err > 9'sd0) && (le_cur > 9'sd0))
                    || ((err < 9'sd0) && (le_cur < 9'sd0));

   assign sum_wide = {sum_cur[15], sum_cur} + {{8{err[8]}}, err};
   always_comb begin
      if (sum_wide[16] != sum_wide[15]) begin
         sum_sat = sum_wide[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         sum_sat = sum_wide[15:0];
      end
   end

   always_comb begin
      last_error_in   = le_cur;
      error_sum_in    = sum_cur;
      white_seen_in   = ws_cur;
      run_finished_in = rf_cur;
      tick.done       = 1'b1;
      tick.err        = err;
      tick.err_sum    = same_sign ? sum_sat : 16'sd0;
      tick.deriv      = {err[8], err} - {le_cur[8], le_cur};
      if (!rf_cur) begin
         white_seen_in = ws_new;
         if (stop) begin
            run_finished_in = 1'b1;
         end else begin
            tick.done     = 1'b0;
            last_error_in = err;
            error_sum_in  = tick.err_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff   <= '0;
         error_sum_ff    <= '0;
         white_seen_ff   <= 1'b0;
         run_finished_ff <= 1'b0;
      end else if (accept) begin
         last_error_ff   <= last_error_in;
         error_sum_ff    <= error_sum_in;
         white_seen_ff   <= white_seen_in;
         run_finished_ff <= run_finished_in;
      end
   end

endmodule

FILE: src/line_follow_pd_steering.sv
// ---------------------------------------------------------------------------
// line_follow_pd_steering
// PID line follower steering for a differential drive: one tick in,
// left and right motor speeds plus a done flag out.
//
//   channel | ports                          | direction
//   req     | req_valid/req_ready + fields   | in, one control tick
//   rsp     | rsp_valid/rsp_ready + fields   | out, one result per tick
//   csr     | csr_valid/csr_ready, index+data| in, register write
//
// One tick per cycle is taken while the rsp channel is not stalled.
// Run state updates at the req transfer; products are registered in the
// middle stage, then summed, rounded and saturated into the output register.
// A stalled rsp holds each stage that is full; empty stages still fill.
// Synchronous reset restores register defaults and clears the run state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "line_follow_pd_steering_macros.svh"

module line_follow_pd_steering (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_first_sample,
   input  logic [6:0]        req_follow_reading,
   input  logic [6:0]        req_find_reading,
   input  logic [19:0]       req_encoder_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [7:0] rsp_left_speed,
   output logic signed [7:0] rsp_right_speed,
   output logic              rsp_done_res,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_wdata
);
   import lfs_pkg::*;

   cfg_type  cfg;
   tick_type tick;

   logic req_accept;
   logic out_take;
   logic en2;
   logic en1;

   logic     v1_ff;
   tick_type t1_ff;

   logic               v2_ff;
   logic               done2_ff;
   logic signed [19:0] p_prod_ff, p_prod_in;
   logic signed [26:0] i_prod_ff, i_prod_in;
   logic signed [20:0] d_prod_ff, d_prod_in;

   logic               rsp_valid_ff;
   logic signed [7:0]  rsp_left_ff, rsp_left_in;
   logic signed [7:0]  rsp_right_ff, rsp_right_in;
   logic               rsp_done_ff;

   logic signed [27:0] total;
   logic [27:0]        mag;
   logic [27:0]        mag_rnd;
   logic [18:0]        quo;
   logic signed [19:0] corr;
   logic signed [20:0] base_w;
   logic signed [20:0] minus_w;
   logic signed [20:0] plus_w;

   logic               speeds_zero;
   logic               speeds_in_range;
   logic               mid_stall;

   lfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfs_track u_track (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .first_sample   (req_first_sample),
      .follow_reading (req_follow_reading),
      .find_reading   (req_find_reading),
      .encoder_count  (req_encoder_count),
      .cfg            (cfg),
      .tick           (tick)
   );

   // advance a stage when it is empty or its successor takes its contents
   assign out_take   = !rsp_valid_ff || rsp_ready;
   assign en2        = !v2_ff || out_take;
   assign en1        = !v1_ff || en2;
   assign req_ready  = en1;
   assign req_accept = req_valid && req_ready;

   // stage 2: gain products
   assign p_prod_in = $signed({1'b0, cfg.gain_p}) * t1_ff.err;
   assign i_prod_in = $signed({1'b0, cfg.gain_i}) * t1_ff.err_sum;
   assign d_prod_in = $signed({1'b0, cfg.gain_d}) * t1_ff.deriv;

   // stage 3: sum, divide by 512 rounding ties away from zero, steer
   assign total   = 28'(p_prod_ff) + 28'(i_prod_ff) + 28'(d_prod_ff);
   assign mag     = total[27] ? 28'(-total) : 28'(total);
   assign mag_rnd = mag + 28'd256;
   assign quo     = mag_rnd[27:9];
   assign corr    = total[27] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign base_w  = 21'(cfg.base_speed);
   assign minus_w = base_w - 21'(corr);
   assign plus_w  = base_w + 21'(corr);

   always_comb begin
      if (done2_ff) begin
         rsp_left_in  = 8'sd0;
         rsp_right_in = 8'sd0;
      end else if (cfg.follow_side) begin
         rsp_left_in  = sat_speed(plus_w);
         rsp_right_in = sat_speed(minus_w);
      end else begin
         rsp_left_in  = sat_speed(minus_w);
         rsp_right_in = sat_speed(plus_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (out_take) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         t1_ff <= tick;
      end
      if (en2 && v1_ff) begin
         done2_ff  <= t1_ff.done;
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
      if (out_take && v2_ff) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_done_ff  <= done2_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_done_res    = rsp_done_ff;

   assign speeds_zero     = (rsp_left_ff == 8'sd0) && (rsp_right_ff == 8'sd0);
   assign speeds_in_range = (rsp_left_ff <= 8'sd100) && (rsp_left_ff >= -8'sd100)
                          && (rsp_right_ff <= 8'sd100) && (rsp_right_ff >= -8'sd100);
   assign mid_stall       = v2_ff && !out_take;

   `LFS_ASSERT_NOW(a_done_zero, rsp_valid_ff && rsp_done_ff, speeds_zero, "done speed nonzero")
   `LFS_ASSERT_NOW(a_speed_range, rsp_valid_ff, speeds_in_range, "speed out of range")
   `LFS_ASSERT_NEXT(a_mid_hold, mid_stall, v2_ff && $stable({done2_ff, p_prod_ff}), "mid lost")

endmodule

FILE: tb/lfs_steering_checker.sv
// ---------------------------------------------------------------------------
// lfs_steering_checker
// Watches the tick, result and register channels of the steering block,
// works out the motor command due for every accepted tick and compares
// each result transfer, field by field, with the oldest command due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_steering_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_first_sample,
   input  logic [6:0]        req_follow_reading,
   input  logic [6:0]        req_find_reading,
   input  logic [19:0]       req_encoder_count,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic signed [7:0] rsp_left_speed,
   input  logic signed [7:0] rsp_right_speed,
   input  logic              rsp_done_res,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_wdata,
   output int                mismatches,
   output int                ticks_answered
);
   import lfs_pkg::*;

   typedef struct packed {
      logic signed [7:0] left;
      logic signed [7:0] right;
      logic              done;
   } wheel_cmd_type;

   localparam cfg_type REGS_AT_RESET = '{
      setpoint_half: 8'd55, gain_p: 10'd77, gain_i: 10'd0, gain_d: 10'd154,
      base_speed: 8'sd30, follow_side: 1'b0, stop_mode: STOP_ENCODER,
      encoder_target: 20'd360};

   localparam int SPEED_MAX = 100;
   localparam int ACC_MAX   = 32767;
   localparam int ACC_MIN   = -32768;

   cfg_type       regs;
   int            prev_err;
   int            err_acc;
   bit            white_seen;
   bit            run_over;
   wheel_cmd_type cmds_due[$];

   function automatic logic signed [7:0] clamp_pct(input longint v);
      if (v > SPEED_MAX) begin
         return 8'sd100;
      end else if (v < -SPEED_MAX) begin
         return -8'sd100;
      end
      return v[7:0];
   endfunction

   function automatic wheel_cmd_type steer_tick(input bit first, input logic [6:0] follow,
                                                input logic [6:0] find_pct,
                                                input logic [19:0] enc);
      wheel_cmd_type cmd;
      bit            stopped;
      int            err;
      int            deriv;
      longint        acc;
      longint        corr;
      longint        base;
      cmd = '0;
      if (first) begin
         prev_err   = 0;
         err_acc    = 0;
         white_seen = 1'b0;
         run_over   = 1'b0;
      end
      if (run_over) begin
         cmd.done = 1'b1;
         return cmd;
      end
      // white is tracked whatever the mode, so a later line mode sees it
      if (find_pct >= WhiteLevel) begin
         white_seen = 1'b1;
      end
      case (regs.stop_mode)
         STOP_ENCODER:     stopped = (enc >= regs.encoder_target);
         STOP_WHITE_BLACK: stopped = white_seen && (find_pct <= BlackLevel);
         default:          stopped = white_seen;
      endcase
      if (stopped) begin
         run_over = 1'b1;
         cmd.done = 1'b1;
         return cmd;
      end

      err = 2 * int'(follow) - int'(regs.setpoint_half);
      if ((err > 0 && prev_err > 0) || (err < 0 && prev_err < 0)) begin
         err_acc = err_acc + err;
         if (err_acc > ACC_MAX) begin
            err_acc = ACC_MAX;
         end else if (err_acc < ACC_MIN) begin
            err_acc = ACC_MIN;
         end
      end else begin
         err_acc = 0;
      end
      deriv = err - prev_err;

      acc = longint'(regs.gain_p) * err + longint'(regs.gain_i) * err_acc
          + longint'(regs.gain_d) * deriv;
      // round to nearest on the magnitude, ties away from zero
      corr = ((acc < 0 ? -acc : acc) + 256) / 512;
      if (acc < 0) begin
         corr = -corr;
      end
      base = longint'(regs.base_speed);
      if (regs.follow_side) begin
         cmd.left  = clamp_pct(base + corr);
         cmd.right = clamp_pct(base - corr);
      end else begin
         cmd.left  = clamp_pct(base - corr);
         cmd.right = clamp_pct(base + corr);
      end
      prev_err = err;
      return cmd;
   endfunction

   always @(posedge clock) begin : watch
      wheel_cmd_type want;
      int            bad;
      bad = 0;
      if (reset) begin
         regs       = REGS_AT_RESET;
         prev_err   = 0;
         err_acc    = 0;
         white_seen = 1'b0;
         run_over   = 1'b0;
         cmds_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SETPOINT:   regs.setpoint_half  = csr_wdata[7:0];
               REG_GAIN_P:     regs.gain_p         = csr_wdata[9:0];
               REG_GAIN_I:     regs.gain_i         = csr_wdata[9:0];
               REG_GAIN_D:     regs.gain_d         = csr_wdata[9:0];
               REG_BASE_SPEED: regs.base_speed     = csr_wdata[7:0];
               REG_FOLLOW:     regs.follow_side    = csr_wdata[0];
               REG_STOP_MODE:  regs.stop_mode      = csr_wdata[1:0];
               REG_ENC_TARGET: regs.encoder_target = csr_wdata[19:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            cmds_due.push_back(steer_tick(req_first_sample, req_follow_reading,
                                          req_find_reading, req_encoder_count));
         end
         if (rsp_valid && rsp_ready) begin
            ticks_answered <= ticks_answered + 1;
            if (cmds_due.size() == 0) begin
               $error("result transfer with no tick outstanding");
               bad++;
            end else begin
               want = cmds_due.pop_front();
               if (rsp_left_speed !== want.left) begin
                  $error("left_speed: expected %0d, got %0d", want.left, rsp_left_speed);
                  bad++;
               end
               if (rsp_right_speed !== want.right) begin
                  $error("right_speed: expected %0d, got %0d", want.right, rsp_right_speed);
                  bad++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
                  bad++;
               end
            end
         end
      end
      if (bad != 0) begin
         mismatches <= mismatches + bad;
      end
   end

endmodule

FILE: tb/line_follow_pd_steering_test.sv
// ---------------------------------------------------------------------------
// line_follow_pd_steering_test
// Drives control ticks and register writes into the steering block, with
// random gaps on the tick channel and random back-pressure on the result
// channel; a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_pd_steering_test;
   import lfs_pkg::*;

   localparam logic [1:0] STOP_UNUSED = 2'd3;
   localparam int SEGMENTS     = 5;
   localparam int SEG_TICKS    = 30;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_first_sample = 1'b0;
   logic [6:0]        req_follow_reading = '0;
   logic [6:0]        req_find_reading = '0;
   logic [19:0]       req_encoder_count = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [7:0] rsp_left_speed;
   logic signed [7:0] rsp_right_speed;
   logic              rsp_done_res;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [19:0]       csr_wdata = '0;

   int      mismatches;
   int      ticks_answered;
   int      ticks_sent = 0;
   int      sender_idle_pct = 33;
   int      receiver_idle_pct = 83;
   cfg_type cur_regs;

   always #6 clock = ~clock;

   line_follow_pd_steering i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_sample   (req_first_sample),
      .req_follow_reading (req_follow_reading),
      .req_find_reading   (req_find_reading),
      .req_encoder_count  (req_encoder_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_done_res       (rsp_done_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   lfs_steering_checker i_check (.*);

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   task automatic send_tick(input bit first, input logic [6:0] follow,
                            input logic [6:0] find_pct, input logic [19:0] enc);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_first_sample   <= first;
      req_follow_reading <= follow;
      req_find_reading   <= find_pct;
      req_encoder_count  <= enc;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic put_reg(input logic [2:0] idx, input logic [19:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drop the tick valid, drain every outstanding result, then rewrite
   // the whole register set
   task automatic set_regs(input cfg_type c);
      req_valid <= 1'b0;
      while (ticks_answered < ticks_sent) @(posedge clock);
      put_reg(REG_SETPOINT,   {12'd0, c.setpoint_half});
      put_reg(REG_GAIN_P,     {10'd0, c.gain_p});
      put_reg(REG_GAIN_I,     {10'd0, c.gain_i});
      put_reg(REG_GAIN_D,     {10'd0, c.gain_d});
      put_reg(REG_BASE_SPEED, {12'd0, c.base_speed});
      put_reg(REG_FOLLOW,     {19'd0, c.follow_side});
      put_reg(REG_STOP_MODE,  {18'd0, c.stop_mode});
      put_reg(REG_ENC_TARGET, c.encoder_target);
      csr_valid <= 1'b0;
      cur_regs = c;
   endtask

   function automatic logic [9:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 10'd0;
         1:       return 10'd1023;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic cfg_type pick_regs();
      cfg_type c;
      c.setpoint_half  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 200));
      c.gain_p         = pick_gain();
      c.gain_i         = pick_gain();
      c.gain_d         = pick_gain();
      c.base_speed     = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 200) - 100);
      c.follow_side    = 1'($urandom_range(0, 1));
      c.stop_mode      = 2'($urandom_range(0, 3));
      c.encoder_target = ($urandom_range(0, 9) == 0) ? 20'($urandom())
                                                      : 20'($urandom_range(0, 1500));
      return c;
   endfunction

   // mostly well-formed runs: a start tick, rising encoder, dark readings
   // with the odd white or black patch; a tenth of the ticks are pure noise
   task automatic run_ticks(input int n);
      int         k;
      int         enc;
      int         pick;
      int         aim;
      bit         first;
      logic [6:0] follow;
      logic [6:0] find_pct;
      enc = 0;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)), 20'($urandom()));
         end else begin
            first = (k == 0) || ($urandom_range(0, 14) == 0);
            enc = first ? 0 : enc + $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
               find_pct = 7'($urandom_range(8, 46));
            end else if (pick < 92) begin
               find_pct = 7'($urandom_range(47, 127));
            end else begin
               find_pct = 7'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 3) == 0) begin
               follow = 7'($urandom_range(0, 127));
            end else begin
               aim = int'(cur_regs.setpoint_half) / 2 + $urandom_range(0, 30) - 15;
               follow = (aim < 0) ? 7'd0 : (aim > 127) ? 7'd127 : 7'(aim);
            end
            send_tick(first, follow, find_pct, 20'(enc));
         end
      end
   endtask

   initial begin : stimulus
      int ph;
      int seg;
      cur_regs = '{setpoint_half: 8'd55, gain_p: 10'd77, gain_i: 10'd0, gain_d: 10'd154,
                   base_speed: 8'sd30, follow_side: 1'b0, stop_mode: STOP_ENCODER,
                   encoder_target: 20'd360};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // values from reset: distance stop at the target, then a finished run
      send_tick(1'b1, 7'd0,   7'd0,   20'd0);
      send_tick(1'b0, 7'd100, 7'd10,  20'd50);
      send_tick(1'b0, 7'd127, 7'd127, 20'd200);
      send_tick(1'b0, 7'd55,  7'd0,   20'd359);
      send_tick(1'b0, 7'd0,   7'd0,   20'd360);
      send_tick(1'b0, 7'd50,  7'd0,   20'hFFFFF);
      send_tick(1'b1, 7'd30,  7'd0,   20'd0);

      // full gains and base beyond range: saturation both ways
      set_regs('{setpoint_half: 8'd255, gain_p: 10'd1023, gain_i: 10'd1023,
                 gain_d: 10'd1023, base_speed: 8'sd127, follow_side: 1'b1,
                 stop_mode: STOP_WHITE, encoder_target: 20'hFFFFF});
      send_tick(1'b1, 7'd0,   7'd0,  20'd0);
      send_tick(1'b0, 7'd0,   7'd20, 20'hFFFFF);
      send_tick(1'b0, 7'd127, 7'd46, 20'd100);
      send_tick(1'b0, 7'd127, 7'd46, 20'd200);
      send_tick(1'b0, 7'd0,   7'd47, 20'd300);
      send_tick(1'b0, 7'd10,  7'd0,  20'd400);

      // zero gains, most negative base, white then black
      set_regs('{setpoint_half: 8'd0, gain_p: 10'd0, gain_i: 10'd0, gain_d: 10'd0,
                 base_speed: 8'h80, follow_side: 1'b0, stop_mode: STOP_WHITE_BLACK,
                 encoder_target: 20'd0});
      send_tick(1'b1, 7'd127, 7'd100, 20'd0);
      send_tick(1'b0, 7'd64,  7'd7,   20'd10);
      send_tick(1'b0, 7'd0,   7'd0,   20'd20);
      send_tick(1'b1, 7'd0,   7'd8,   20'd0);

      // white seen in distance mode, then a line mode mid-run stops at once
      set_regs('{setpoint_half: 8'd100, gain_p: 10'd300, gain_i: 10'd50,
                 gain_d: 10'd600, base_speed: -8'sd30, follow_side: 1'b1,
                 stop_mode: STOP_ENCODER, encoder_target: 20'd1000});
      send_tick(1'b1, 7'd40, 7'd80, 20'd5);
      set_regs('{setpoint_half: 8'd100, gain_p: 10'd300, gain_i: 10'd50,
                 gain_d: 10'd600, base_speed: -8'sd30, follow_side: 1'b1,
                 stop_mode: STOP_UNUSED, encoder_target: 20'd1000});
      send_tick(1'b0, 7'd40, 7'd0, 20'd6);

      // zero target stops on the first tick
      set_regs('{setpoint_half: 8'd100, gain_p: 10'd300, gain_i: 10'd50,
                 gain_d: 10'd600, base_speed: -8'sd30, follow_side: 1'b0,
                 stop_mode: STOP_ENCODER, encoder_target: 20'd0});
      send_tick(1'b1, 7'd70, 7'd20, 20'd0);
      send_tick(1'b0, 7'd70, 7'd20, 20'd0);

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct   = 33;
               receiver_idle_pct = 83;
            end
            1: begin
               sender_idle_pct   = 83;
               receiver_idle_pct = 33;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (seg = 0; seg < SEGMENTS; seg++) begin
            set_regs(pick_regs());
            run_ticks(SEG_TICKS);
         end
      end
      req_valid <= 1'b0;

      while (ticks_answered < ticks_sent) @(posedge clock);
      // catch any stray result after the last one due
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
